>>> hw/rtl/sliding_window_variance_monitor_defines.svh
// Assertion helpers shared by the RTL files of this block.
`ifndef SLIDING_WINDOW_VARIANCE_MONITOR_DEFINES_SVH
`define SLIDING_WINDOW_VARIANCE_MONITOR_DEFINES_SVH

`ifndef ASSERT_OFF
// clocked check, masked while reset is high
`define SWVM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check that also holds across reset
`define SWVM_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SWVM_ASSERT(label, clk, rst, prop, msg)
`define SWVM_ASSERT_NR(label, clk, prop, msg)
`endif

`endif

>>> hw/rtl/swvm_pkg.sv
package swvm_pkg;

   localparam int SAMPLE_W    = 24;              // Q12.12 energy sample
   localparam int SQ_W        = 2 * SAMPLE_W - 1; // one squared sample, unsigned
   localparam int LEN_W       = 9;               // window_length register
   localparam int THRESH_W    = 64;              // variance_threshold register
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = THRESH_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WINDOW_LENGTH      = 1'b0,
      CSR_VARIANCE_THRESHOLD = 1'b1
   } csr_index_type;

   // control travelling with an item between pipeline sections
   typedef struct packed {
      logic valid;
      logic window_full;
   } stage_tag_type;

endpackage

>>> hw/rtl/swvm_req_if.sv
interface swvm_req_if;
   import swvm_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] energy_sample;
   logic                       cell_change;

   modport source (output valid, output energy_sample, output cell_change, input ready);
   modport sink   (input valid, input energy_sample, input cell_change, output ready);
endinterface

>>> hw/rtl/swvm_rsp_if.sv
interface swvm_rsp_if;
   logic valid;
   logic ready;
   logic energy_active;
   logic cell_active;
   logic window_full;

   modport source (output valid, output energy_active, output cell_active,
                   output window_full, input ready);
   modport sink   (input valid, input energy_active, input cell_active,
                   input window_full, output ready);
endinterface

>>> hw/rtl/swvm_ram.sv
module swvm_ram #(
   parameter int WIDTH = 25,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read at the written address returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hw/rtl/swvm_window.sv
`include "sliding_window_variance_monitor_defines.svh"

module swvm_window #(
   parameter int WINDOW_MAX = 256
) (
   input  logic                                  clock,
   input  logic                                  reset,
   swvm_req_if.sink                              req_chan,
   input  logic                                  clear,
   input  logic [$clog2(WINDOW_MAX+1)-1:0]       window_n,
   input  logic                                  out_ready,
   output swvm_pkg::stage_tag_type               out_tag,
   output logic signed [swvm_pkg::SAMPLE_W-1:0]  out_sample,
   output logic signed [swvm_pkg::SAMPLE_W-1:0]  out_old_sample,
   output logic                                  out_flag,
   output logic                                  out_old_flag,
   output logic [swvm_pkg::SQ_W-1:0]             out_sq_new,
   output logic [swvm_pkg::SQ_W-1:0]             out_sq_old
);
   import swvm_pkg::*;

   localparam int POS_W = $clog2(WINDOW_MAX);
   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int RAM_W = SAMPLE_W + 1;

   logic             accept;
   logic             s0_load;
   logic             s1_load;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] steps_ff, steps_in;
   logic [CNT_W:0]   pos_inc;
   logic             evict_now;
   logic             full_now;
   logic [RAM_W-1:0] ram_rd_data;

   logic                       s0_valid_ff;
   logic                       s0_evict_ff;
   logic                       s0_full_ff;
   logic signed [SAMPLE_W-1:0] s0_sample_ff;
   logic                       s0_flag_ff;

   logic signed [SAMPLE_W-1:0]   old_sample;
   logic                         old_flag;
   logic signed [2*SAMPLE_W-1:0] prod_new;
   logic signed [2*SAMPLE_W-1:0] prod_old;

   logic                       s1_valid_ff;
   logic                       s1_full_ff;
   logic signed [SAMPLE_W-1:0] s1_sample_ff;
   logic signed [SAMPLE_W-1:0] s1_old_sample_ff;
   logic                       s1_flag_ff;
   logic                       s1_old_flag_ff;
   logic [SQ_W-1:0]            s1_sq_new_ff;
   logic [SQ_W-1:0]            s1_sq_old_ff;

   assign s1_load        = !s1_valid_ff || out_ready;
   assign s0_load        = !s0_valid_ff || s1_load;
   assign req_chan.ready = s0_load;
   assign accept         = req_chan.valid && s0_load;

   // ring position and fill level
   always_comb begin
      evict_now = (steps_ff >= window_n);
      steps_in  = evict_now ? steps_ff : steps_ff + CNT_W'(1);
      full_now  = (steps_in >= window_n);
      pos_inc   = (CNT_W+1)'(pos_ff) + (CNT_W+1)'(1);
      pos_in    = (pos_inc >= (CNT_W+1)'(window_n)) ? '0 : POS_W'(pos_inc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         steps_ff    <= '0;
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (clear) begin
            pos_ff   <= '0;
            steps_ff <= '0;
         end else if (accept) begin
            pos_ff   <= pos_in;
            steps_ff <= steps_in;
         end
         if (s0_load) begin
            s0_valid_ff <= req_chan.valid;
         end
         if (s1_load) begin
            s1_valid_ff <= s0_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s0_evict_ff  <= evict_now;
         s0_full_ff   <= full_now;
         s0_sample_ff <= req_chan.energy_sample;
         s0_flag_ff   <= req_chan.cell_change;
      end
   end

   // same slot is read (old entry) and overwritten on each transfer
   swvm_ram #(
      .WIDTH (RAM_W),
      .DEPTH (WINDOW_MAX)
   ) u_ring (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (pos_ff),
      .wr_data ({req_chan.cell_change, req_chan.energy_sample}),
      .rd_en   (accept),
      .rd_addr (pos_ff),
      .rd_data (ram_rd_data)
   );

   // entry leaving the window, zero while still filling
   always_comb begin
      old_sample = s0_evict_ff ? $signed(ram_rd_data[SAMPLE_W-1:0]) : '0;
      old_flag   = s0_evict_ff && ram_rd_data[SAMPLE_W];
   end

   assign prod_new = (2*SAMPLE_W)'(s0_sample_ff) * (2*SAMPLE_W)'(s0_sample_ff);
   assign prod_old = (2*SAMPLE_W)'(old_sample) * (2*SAMPLE_W)'(old_sample);

   always_ff @(posedge clock) begin
      if (s1_load && s0_valid_ff) begin
         s1_full_ff       <= s0_full_ff;
         s1_sample_ff     <= s0_sample_ff;
         s1_old_sample_ff <= old_sample;
         s1_flag_ff       <= s0_flag_ff;
         s1_old_flag_ff   <= old_flag;
         s1_sq_new_ff     <= prod_new[SQ_W-1:0];
         s1_sq_old_ff     <= prod_old[SQ_W-1:0];
      end
   end

   assign out_tag.valid       = s1_valid_ff;
   assign out_tag.window_full = s1_full_ff;
   assign out_sample          = s1_sample_ff;
   assign out_old_sample      = s1_old_sample_ff;
   assign out_flag            = s1_flag_ff;
   assign out_old_flag        = s1_old_flag_ff;
   assign out_sq_new          = s1_sq_new_ff;
   assign out_sq_old          = s1_sq_old_ff;

   `SWVM_ASSERT(a_pos_in_window, clock, reset,
      CNT_W'(pos_ff) < window_n, "write position past window")
   `SWVM_ASSERT(a_steps_saturate, clock, reset, steps_ff <= window_n, "fill count past window")
   `SWVM_ASSERT(a_stall_source, clock, reset,
      !req_chan.ready |-> s0_valid_ff && s1_valid_ff && !out_ready,
      "input stalled without full stages")
endmodule

>>> hw/rtl/swvm_stats.sv
module swvm_stats #(
   parameter int WINDOW_MAX = 256
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  logic                                                   clear,
   input  swvm_pkg::stage_tag_type                                in_tag,
   input  logic signed [swvm_pkg::SAMPLE_W-1:0]                   in_sample,
   input  logic signed [swvm_pkg::SAMPLE_W-1:0]                   in_old_sample,
   input  logic                                                   in_flag,
   input  logic                                                   in_old_flag,
   input  logic [swvm_pkg::SQ_W-1:0]                              in_sq_new,
   input  logic [swvm_pkg::SQ_W-1:0]                              in_sq_old,
   output logic                                                   in_ready,
   output swvm_pkg::stage_tag_type                                out_tag,
   output logic signed [swvm_pkg::SAMPLE_W+$clog2(WINDOW_MAX)-1:0] out_sum,
   output logic [swvm_pkg::SQ_W+$clog2(WINDOW_MAX)-1:0]           out_sum_sq,
   output logic                                                   out_flag_any,
   input  logic                                                   out_ready
);
   import swvm_pkg::*;

   localparam int LOG_W = $clog2(WINDOW_MAX);
   localparam int SUM_W = SAMPLE_W + LOG_W;
   localparam int SQS_W = SQ_W + LOG_W;
   localparam int CNT_W = $clog2(WINDOW_MAX + 1);

   logic                    load;
   logic                    take;
   logic                    valid_ff;
   logic                    full_ff;
   logic                    flag_any_ff;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [SQS_W-1:0]        sum_sq_ff, sum_sq_in;
   logic [CNT_W-1:0]        flag_cnt_ff, flag_cnt_in;

   assign load     = !valid_ff || out_ready;
   assign in_ready = load;
   assign take     = load && in_tag.valid;

   // modular update; the true window totals always fit
   always_comb begin
      sum_in      = sum_ff + SUM_W'(in_sample) - SUM_W'(in_old_sample);
      sum_sq_in   = sum_sq_ff + SQS_W'(in_sq_new) - SQS_W'(in_sq_old);
      flag_cnt_in = flag_cnt_ff + CNT_W'(in_flag) - CNT_W'(in_old_flag);
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         sum_ff      <= '0;
         sum_sq_ff   <= '0;
         flag_cnt_ff <= '0;
      end else if (take) begin
         sum_ff      <= sum_in;
         sum_sq_ff   <= sum_sq_in;
         flag_cnt_ff <= flag_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         full_ff     <= in_tag.window_full;
         flag_any_ff <= (flag_cnt_in != '0);
      end
   end

   assign out_tag.valid       = valid_ff;
   assign out_tag.window_full = full_ff;
   assign out_sum             = sum_ff;
   assign out_sum_sq          = sum_sq_ff;
   assign out_flag_any        = flag_any_ff;
endmodule

>>> hw/rtl/swvm_judge.sv
module swvm_judge #(
   parameter int WINDOW_MAX = 256
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  swvm_pkg::stage_tag_type                                in_tag,
   input  logic signed [swvm_pkg::SAMPLE_W+$clog2(WINDOW_MAX)-1:0] in_sum,
   input  logic [swvm_pkg::SQ_W+$clog2(WINDOW_MAX)-1:0]           in_sum_sq,
   input  logic                                                   in_flag_any,
   output logic                                                   in_ready,
   input  logic [$clog2(WINDOW_MAX+1)-1:0]                        window_n,
   input  logic [swvm_pkg::THRESH_W-1:0]                          threshold,
   swvm_rsp_if.source                                             rsp_chan
);
   import swvm_pkg::*;

   localparam int LOG_W = $clog2(WINDOW_MAX);
   localparam int SUM_W = SAMPLE_W + LOG_W;
   localparam int SQS_W = SQ_W + LOG_W;
   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int VAR_W = CNT_W + SQS_W;
   localparam int CMP_W = (VAR_W > THRESH_W) ? VAR_W : THRESH_W;

   logic load3, load4, load5;

   logic [VAR_W-1:0]          len_prod;
   logic signed [2*SUM_W-1:0] sum_prod;

   logic             s3_valid_ff, s3_full_ff, s3_flag_ff;
   logic [VAR_W-1:0] s3_len_prod_ff, s3_sum_prod_ff;
   logic             s4_valid_ff, s4_full_ff, s4_flag_ff;
   logic [VAR_W-1:0] s4_diff_ff;
   logic             s5_valid_ff;
   logic             s5_energy_ff, s5_cell_ff, s5_full_ff;
   logic             above;

   assign load5    = !s5_valid_ff || rsp_chan.ready;
   assign load4    = !s4_valid_ff || load5;
   assign load3    = !s3_valid_ff || load4;
   assign in_ready = load3;

   // N*sum_sq and sum^2, each exact at VAR_W
   assign len_prod = VAR_W'(window_n) * VAR_W'(in_sum_sq);
   assign sum_prod = (2*SUM_W)'(in_sum) * (2*SUM_W)'(in_sum);

   assign above = (CMP_W'(s4_diff_ff) > CMP_W'(threshold));

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (load3) s3_valid_ff <= in_tag.valid;
         if (load4) s4_valid_ff <= s3_valid_ff;
         if (load5) s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load3 && in_tag.valid) begin
         s3_full_ff     <= in_tag.window_full;
         s3_flag_ff     <= in_flag_any;
         s3_len_prod_ff <= len_prod;
         s3_sum_prod_ff <= VAR_W'(sum_prod);
      end
      if (load4 && s3_valid_ff) begin
         s4_full_ff <= s3_full_ff;
         s4_flag_ff <= s3_flag_ff;
         s4_diff_ff <= s3_len_prod_ff - s3_sum_prod_ff;
      end
      if (load5 && s4_valid_ff) begin
         s5_full_ff   <= s4_full_ff;
         s5_energy_ff <= !s4_full_ff || above;
         s5_cell_ff   <= !s4_full_ff || s4_flag_ff;
      end
   end

   assign rsp_chan.valid         = s5_valid_ff;
   assign rsp_chan.energy_active = s5_energy_ff;
   assign rsp_chan.cell_active   = s5_cell_ff;
   assign rsp_chan.window_full   = s5_full_ff;
endmodule

>>> hw/rtl/sliding_window_variance_monitor.sv
// Channel    Dir  Payload                                     Transfer
// req_chan   in   energy_sample (s24 Q12.12), cell_change     valid && ready
// rsp_chan   out  energy_active, cell_active, window_full     valid && ready
// csr_*      in   csr_index, csr_write_data (64b)             csr_write_en
//
// One transfer per cycle in each direction when rsp_chan.ready stays high.
// A request transfer passes through the pipeline stages ring read, squares,
// running sums, products, difference and compare on the way to its response.
// Reset: synchronous, active high; window empty, length 16, threshold 0.
// The ring needs no clearing pass: an old entry is only used after being written.
// A stall on rsp_chan fills the empty stages first; req_chan.ready drops only
// when every stage holds an item.
`include "sliding_window_variance_monitor_defines.svh"

module sliding_window_variance_monitor #(
   parameter int WINDOW_MAX = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   swvm_req_if.sink                            req_chan,
   swvm_rsp_if.source                          rsp_chan,
   input  logic                                csr_write_en,
   input  logic [swvm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [swvm_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import swvm_pkg::*;

   localparam int LOG_W   = $clog2(WINDOW_MAX);
   localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W   = SAMPLE_W + LOG_W;
   localparam int SQS_W   = SQ_W + LOG_W;
   localparam int RESET_N = (16 > WINDOW_MAX) ? WINDOW_MAX : 16;

   logic [CNT_W-1:0]    window_n_ff, window_n_in;
   logic [THRESH_W-1:0] threshold_ff;
   logic [LEN_W-1:0]    len_raw;
   logic                clear;

   stage_tag_type              win_tag;
   logic signed [SAMPLE_W-1:0] win_sample, win_old_sample;
   logic                       win_flag, win_old_flag;
   logic [SQ_W-1:0]            win_sq_new, win_sq_old;
   logic                       stats_ready;

   stage_tag_type           stats_tag;
   logic signed [SUM_W-1:0] stats_sum;
   logic [SQS_W-1:0]        stats_sum_sq;
   logic                    stats_flag_any;
   logic                    judge_ready;

   // register writes; a new length also empties the window
   assign len_raw = csr_write_data[LEN_W-1:0];
   assign clear   = csr_write_en && (csr_index == CSR_WINDOW_LENGTH);

   // zero length means one; longer than the ring means the whole ring
   always_comb begin
      if (len_raw == '0) begin
         window_n_in = CNT_W'(1);
      end else if (32'(len_raw) > 32'(WINDOW_MAX)) begin
         window_n_in = CNT_W'(WINDOW_MAX);
      end else begin
         window_n_in = CNT_W'(len_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_n_ff  <= CNT_W'(RESET_N);
         threshold_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_WINDOW_LENGTH: begin
               window_n_ff <= window_n_in;
            end
            CSR_VARIANCE_THRESHOLD: begin
               threshold_ff <= csr_write_data[THRESH_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ring, eviction and per-sample squares
   swvm_window #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_window (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .clear          (clear),
      .window_n       (window_n_ff),
      .out_ready      (stats_ready),
      .out_tag        (win_tag),
      .out_sample     (win_sample),
      .out_old_sample (win_old_sample),
      .out_flag       (win_flag),
      .out_old_flag   (win_old_flag),
      .out_sq_new     (win_sq_new),
      .out_sq_old     (win_sq_old)
   );

   // running sum, sum of squares, set-flag count
   swvm_stats #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_stats (
      .clock         (clock),
      .reset         (reset),
      .clear         (clear),
      .in_tag        (win_tag),
      .in_sample     (win_sample),
      .in_old_sample (win_old_sample),
      .in_flag       (win_flag),
      .in_old_flag   (win_old_flag),
      .in_sq_new     (win_sq_new),
      .in_sq_old     (win_sq_old),
      .in_ready      (stats_ready),
      .out_tag       (stats_tag),
      .out_sum       (stats_sum),
      .out_sum_sq    (stats_sum_sq),
      .out_flag_any  (stats_flag_any),
      .out_ready     (judge_ready)
   );

   // N*sum_sq - sum^2 against the threshold, result register
   swvm_judge #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_judge (
      .clock       (clock),
      .reset       (reset),
      .in_tag      (stats_tag),
      .in_sum      (stats_sum),
      .in_sum_sq   (stats_sum_sq),
      .in_flag_any (stats_flag_any),
      .in_ready    (judge_ready),
      .window_n    (window_n_ff),
      .threshold   (threshold_ff),
      .rsp_chan    (rsp_chan)
   );

   `SWVM_ASSERT(a_filling_is_active, clock, reset, rsp_chan.valid && !rsp_chan.window_full |-> rsp_chan.energy_active && rsp_chan.cell_active, "inactive output while window filling")
   `SWVM_ASSERT_NR(a_reset_drains, clock, reset |=> !rsp_chan.valid, "response valid right after reset")
endmodule
